// ----- rtl/est_pkg.sv -----
`timescale 1ns / 1ps

package est_pkg;

  // Escape phases
  localparam logic [1:0] PH_IDLE = 2'd0;  // nothing pending
  localparam logic [1:0] PH_BS   = 2'd1;  // backslash pending
  localparam logic [1:0] PH_BSX  = 2'd2;  // backslash-x pending
  localparam logic [1:0] PH_BSXD = 2'd3;  // backslash-x and one digit pending

  // Characters
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_LOWER_X   = 8'h78;

  // Register indexes (byte address 8*i)
  localparam logic [1:0] REG_TABLE_SIZE = 2'd0;
  localparam logic [1:0] REG_FROM_CHARS = 2'd1;
  localparam logic [1:0] REG_TO_CHARS   = 2'd2;
  localparam logic [1:0] REG_HEX_ENABLE = 2'd3;

  localparam int MAX_OUT = 4;

  // Register contents as seen by the front end
  typedef struct packed {
    logic [3:0]  table_size;
    logic [63:0] from_chars;
    logic [63:0] to_chars;
    logic        hex_enable;
  } cfg_t;

  // Output bytes caused by one input transfer; data[0] goes out first
  typedef struct packed {
    logic [MAX_OUT-1:0][7:0] data;
    logic [2:0]              cnt;
    logic                    last;
  } pkt_t;

  // Append one byte to a packet, dropping bytes beyond MAX_OUT
  function automatic pkt_t pkt_push(pkt_t p, logic [7:0] b);
    pkt_t r;
    r = p;
    if (p.cnt < 3'(MAX_OUT)) begin
      r.data[p.cnt[1:0]] = b;
      r.cnt = p.cnt + 3'd1;
    end
    return r;
  endfunction

  // Hex digit decode, either case
  function automatic logic [4:0] hex_decode(logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h41 + 8'd10)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h61 + 8'd10)};
    end
    return r;
  endfunction

endpackage

// ----- rtl/est_front.sv -----
`timescale 1ns / 1ps

// Accepts input bytes, tracks the escape phase and turns each byte into a
// packet of zero to four output bytes.
module est_front #(
  parameter int TABLE_ENTRIES = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  est_pkg::cfg_t     cfg,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_byte,
  input  logic              in_last,
  input  logic              q_full,
  output logic              q_push,
  output est_pkg::pkt_t     q_pkt
);

  logic [1:0] phase, phase_next;
  logic [3:0] first_digit, first_digit_next;
  logic [7:0] first_digit_char, first_digit_char_next;

  logic       accept;
  logic [3:0] lim;
  logic       rb_ok, rx_ok;
  logic [7:0] rb, rx;
  logic [4:0] hv;
  est_pkg::pkt_t pk;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // Table limit: clamp table_size to the number of built entries
  assign lim = (cfg.table_size > 4'(TABLE_ENTRIES)) ? 4'(TABLE_ENTRIES) : cfg.table_size;

  // Table lookups for the current byte and for 'x'; lowest index wins
  always_comb begin
    rb_ok = 1'b0;
    rb    = 8'd0;
    rx_ok = 1'b0;
    rx    = 8'd0;
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (4'(i) < lim && cfg.from_chars[8*i +: 8] == in_byte) begin
        rb_ok = 1'b1;
        rb    = cfg.to_chars[8*i +: 8];
      end
      if (4'(i) < lim && cfg.from_chars[8*i +: 8] == est_pkg::CH_LOWER_X) begin
        rx_ok = 1'b1;
        rx    = cfg.to_chars[8*i +: 8];
      end
    end
  end

  assign hv = est_pkg::hex_decode(in_byte);

  // Packet build and next phase
  always_comb begin
    phase_next            = phase;
    first_digit_next      = first_digit;
    first_digit_char_next = first_digit_char;
    pk                    = '0;

    unique case (phase)
      est_pkg::PH_IDLE: begin
        if (in_byte == est_pkg::CH_BACKSLASH) begin
          phase_next = est_pkg::PH_BS;
        end else begin
          pk = est_pkg::pkt_push(pk, in_byte);
        end
      end
      est_pkg::PH_BS: begin
        if (cfg.hex_enable && in_byte == est_pkg::CH_LOWER_X) begin
          phase_next = est_pkg::PH_BSX;
        end else if (rb_ok) begin
          pk = est_pkg::pkt_push(pk, rb);
          phase_next = est_pkg::PH_IDLE;
        end else begin
          pk = est_pkg::pkt_push(pk, est_pkg::CH_BACKSLASH);
          if (in_byte == est_pkg::CH_BACKSLASH) begin
            phase_next = est_pkg::PH_BS;
          end else begin
            pk = est_pkg::pkt_push(pk, in_byte);
            phase_next = est_pkg::PH_IDLE;
          end
        end
      end
      est_pkg::PH_BSX: begin
        if (hv[4]) begin
          first_digit_next      = hv[3:0];
          first_digit_char_next = in_byte;
          phase_next            = est_pkg::PH_BSXD;
        end else begin
          if (rx_ok) begin
            pk = est_pkg::pkt_push(pk, rx);
          end else begin
            pk = est_pkg::pkt_push(pk, est_pkg::CH_BACKSLASH);
            pk = est_pkg::pkt_push(pk, est_pkg::CH_LOWER_X);
          end
          if (in_byte == est_pkg::CH_BACKSLASH) begin
            phase_next = est_pkg::PH_BS;
          end else begin
            pk = est_pkg::pkt_push(pk, in_byte);
            phase_next = est_pkg::PH_IDLE;
          end
        end
      end
      est_pkg::PH_BSXD: begin
        if (hv[4]) begin
          pk = est_pkg::pkt_push(pk, {first_digit, hv[3:0]});
          phase_next = est_pkg::PH_IDLE;
        end else begin
          if (rx_ok) begin
            pk = est_pkg::pkt_push(pk, rx);
          end else begin
            pk = est_pkg::pkt_push(pk, est_pkg::CH_BACKSLASH);
            pk = est_pkg::pkt_push(pk, est_pkg::CH_LOWER_X);
          end
          // held digit is never a backslash
          pk = est_pkg::pkt_push(pk, first_digit_char);
          if (in_byte == est_pkg::CH_BACKSLASH) begin
            phase_next = est_pkg::PH_BS;
          end else begin
            pk = est_pkg::pkt_push(pk, in_byte);
            phase_next = est_pkg::PH_IDLE;
          end
        end
      end
      default: phase_next = est_pkg::PH_IDLE;
    endcase

    // End of string: flush whatever is pending
    if (in_last) begin
      unique case (phase_next)
        est_pkg::PH_BS: begin
          pk = est_pkg::pkt_push(pk, est_pkg::CH_BACKSLASH);
        end
        est_pkg::PH_BSX, est_pkg::PH_BSXD: begin
          if (rx_ok) begin
            pk = est_pkg::pkt_push(pk, rx);
          end else begin
            pk = est_pkg::pkt_push(pk, est_pkg::CH_BACKSLASH);
            pk = est_pkg::pkt_push(pk, est_pkg::CH_LOWER_X);
          end
          if (phase_next == est_pkg::PH_BSXD) begin
            pk = est_pkg::pkt_push(pk, first_digit_char_next);
          end
        end
        default: ;
      endcase
      phase_next            = est_pkg::PH_IDLE;
      first_digit_next      = 4'd0;
      first_digit_char_next = 8'd0;
      pk.last               = 1'b1;
    end
  end

  assign q_push = accept && (pk.cnt != 3'd0);
  assign q_pkt  = pk;

  // Escape state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= est_pkg::PH_IDLE;
      first_digit      <= 4'd0;
      first_digit_char <= 8'd0;
    end else if (accept) begin
      phase            <= phase_next;
      first_digit      <= first_digit_next;
      first_digit_char <= first_digit_char_next;
    end
  end

endmodule

// ----- rtl/est_queue.sv -----
`timescale 1ns / 1ps

// Packet queue between front and back end
module est_queue #(
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  est_pkg::pkt_t push_pkt,
  output logic          full,
  input  logic          pop,
  output logic          empty,
  output est_pkg::pkt_t head
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  est_pkg::pkt_t     mem [DEPTH];
  logic [AW-1:0]     wptr, rptr;
  logic [AW:0]       count;
  logic              do_push, do_pop;

  assign full    = (count == (AW+1)'(DEPTH));
  assign empty   = (count == '0);
  assign head    = mem[rptr];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= push_pkt;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + AW'(1);
      end
      if (do_pop) begin
        rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + AW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + (AW+1)'(1);
      end else if (do_pop && !do_push) begin
        count <= count - (AW+1)'(1);
      end
    end
  end

endmodule

// ----- rtl/est_back.sv -----
`timescale 1ns / 1ps

// Takes packets from the queue and sends their bytes one per transfer
module est_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_empty,
  input  est_pkg::pkt_t q_head,
  output logic          q_pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    out_byte,
  output logic          out_last
);

  est_pkg::pkt_t cur;
  logic [1:0]    idx;
  logic          busy;
  logic          final_byte, xfer, take;

  assign final_byte = ({1'b0, idx} + 3'd1) == cur.cnt;
  assign xfer       = busy && out_ready;
  assign take       = !busy || (xfer && final_byte);
  assign q_pop      = take && !q_empty;

  assign out_valid = busy;
  assign out_byte  = cur.data[idx];
  assign out_last  = cur.last && final_byte;

  // Current packet and byte index
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= 2'd0;
    end else if (take) begin
      busy <= !q_empty;
      idx  <= 2'd0;
    end else if (xfer) begin
      idx <= idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_head;
    end
  end

endmodule

// ----- rtl/escape_sequence_translator_top.sv -----
`timescale 1ns / 1ps

// Escape sequence translator. Text bytes come in on the s_ stream (tlast on
// the final byte of a string) and translated bytes leave on the m_ stream.
// With hex_enable set, backslash-x and two hex digits become one byte;
// otherwise backslash and a character from the from/to table (up to
// TABLE_ENTRIES pairs, lowest index wins) become its replacement; unmatched
// escapes pass through, and pending bytes flush on tlast. One input byte is
// accepted per cycle; each one yields zero to four output bytes, and the
// output side sends one byte per cycle while m_tready is high. A queue of
// QUEUE_DEPTH packets between the input classifier and the output serializer
// absorbs the bursts of input bytes that expand into more than one byte; the
// input stalls only while that queue is full. Each packet is registered in
// the queue, then in the serializer. Registers sit at byte addresses 0
// (table_size), 8 (from_chars), 16 (to_chars) and 24 (hex_enable, reset 1).
module escape_sequence_translator_top #(
  parameter int TABLE_ENTRIES = 8,
  parameter int QUEUE_DEPTH   = 4
) (
  input  logic        clk,
  input  logic        rst,
  // Input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] in_byte
  input  logic        s_tlast,   // in_last
  // Output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] out_byte
  output logic        m_tlast,   // out_last
  // Configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  est_pkg::cfg_t cfg;
  logic          cfg_wr;
  logic          q_push, q_full, q_pop, q_empty;
  est_pkg::pkt_t q_pkt, q_head;

  // Configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.table_size <= 4'd0;
      cfg.from_chars <= 64'd0;
      cfg.to_chars   <= 64'd0;
      cfg.hex_enable <= 1'b1;
    end else if (cfg_wr) begin
      unique case (paddr[4:3])
        est_pkg::REG_TABLE_SIZE: cfg.table_size <= pwdata[3:0];
        est_pkg::REG_FROM_CHARS: cfg.from_chars <= pwdata;
        est_pkg::REG_TO_CHARS:   cfg.to_chars   <= pwdata;
        est_pkg::REG_HEX_ENABLE: cfg.hex_enable <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Register read
  always_comb begin
    unique case (paddr[4:3])
      est_pkg::REG_TABLE_SIZE: prdata = {60'd0, cfg.table_size};
      est_pkg::REG_FROM_CHARS: prdata = cfg.from_chars;
      est_pkg::REG_TO_CHARS:   prdata = cfg.to_chars;
      est_pkg::REG_HEX_ENABLE: prdata = {63'd0, cfg.hex_enable};
      default:                 prdata = 64'd0;
    endcase
  end

  est_front #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_byte  (s_tdata),
    .in_last  (s_tlast),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_pkt    (q_pkt)
  );

  est_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_pkt (q_pkt),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head     (q_head)
  );

  est_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_byte  (m_tdata),
    .out_last  (m_tlast)
  );

endmodule

// ----- rtl/est_checker.sv -----
`timescale 1ns / 1ps

module est_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [7:0]  m_tdata,
  input logic        m_tlast,
  input logic        psel,
  input logic        pwrite,
  input logic [4:0]  paddr,
  input logic [63:0] prdata
);

  // A stalled output byte holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output transfer changed while stalled");

  // Reset empties the output side
  a_rst_out: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid right after reset");

  // Queue is empty after reset, so input is open
  a_rst_in: assert property (@(posedge clk) rst |=> s_tready)
    else $error("input not ready right after reset");

  // Hex decoding is on out of reset
  a_rst_hex: assert property (@(posedge clk)
    $past(rst) && psel && !pwrite && paddr == {est_pkg::REG_HEX_ENABLE, 3'b000}
    |-> prdata == 64'd1)
    else $error("hex_enable not set after reset");

endmodule

bind escape_sequence_translator_top est_checker u_est_checker (.*);
